// ===== rtl/keypad_calculator_controller_unit_defines.svh =====
// assertion macros for the keypad calculator controller checker
// no dependencies
`ifndef KEYPAD_CALCULATOR_CONTROLLER_UNIT_DEFINES_SVH
`define KEYPAD_CALCULATOR_CONTROLLER_UNIT_DEFINES_SVH

// same-cycle implication
`define KCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/kcc_pkg.sv =====
// shared types and constants for the keypad calculator controller
// no dependencies
package kcc_pkg;

    localparam int MAX_DIGITS_DEF = 3;

    localparam logic [7:0] KEY_PCT   = 8'd37;
    localparam logic [7:0] KEY_PLUS  = 8'd43;
    localparam logic [7:0] KEY_MINUS = 8'd45;
    localparam logic [7:0] KEY_STAR  = 8'd42;
    localparam logic [7:0] KEY_SLASH = 8'd47;
    localparam logic [7:0] KEY_EQ    = 8'd61;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    localparam logic [1:0] KIND_IGNORED  = 2'd0;
    localparam logic [1:0] KIND_DIGIT    = 2'd1;
    localparam logic [1:0] KIND_OPERATOR = 2'd2;
    localparam logic [1:0] KIND_RESULT   = 2'd3;

    typedef struct packed {
        logic [7:0] key;
        logic [7:0] echo;
        logic       is_end_op;
        logic       is_eq;
        logic [1:0] op;
    } kcc_item_t;

    typedef struct packed {
        logic busy;
        logic done;
    } kcc_div_status_t;

    typedef struct packed {
        logic start;
        logic ack;
    } kcc_div_ctrl_t;

endpackage

// ===== rtl/kcc_front.sv =====
// front end: classifies key transactions and queues them for the back end
// depends on kcc_pkg
module kcc_front
    import kcc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_key,
    output logic       q_valid,
    output kcc_item_t  q_item,
    input  logic       q_pop
);

    kcc_item_t  mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    kcc_item_t  cls;

    always_comb begin
        cls.key       = s_key;
        cls.echo      = (s_key == KEY_PCT) ? KEY_SLASH : s_key;
        cls.is_end_op = (s_key == KEY_PCT) || (s_key == KEY_PLUS) || (s_key == KEY_MINUS) ||
                        (s_key == KEY_STAR) || (s_key == KEY_SLASH);
        cls.is_eq     = (s_key == KEY_EQ);
        priority if (s_key == KEY_PLUS) begin
            cls.op = OP_ADD;
        end else if (s_key == KEY_MINUS) begin
            cls.op = OP_SUB;
        end else if (s_key == KEY_STAR) begin
            cls.op = OP_MUL;
        end else begin
            cls.op = OP_DIV;
        end
    end

    assign s_ready = (count_reg != 2'd2);
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = q_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= cls;
        end
    end

endmodule

// ===== rtl/kcc_divider.sv =====
// restoring 16-bit unsigned divider, one quotient bit per cycle
// depends on kcc_pkg
module kcc_divider
    import kcc_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  kcc_div_ctrl_t   ctrl,
    input  logic [15:0]     dividend,
    input  logic [15:0]     divisor,
    output kcc_div_status_t status,
    output logic [15:0]     quotient
);

    logic [15:0] rem_reg, rem_next;
    logic [15:0] quo_reg, quo_next;
    logic [15:0] dvs_reg, dvs_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [16:0] shifted;
    logic [16:0] diff;

    assign shifted = {rem_reg, quo_reg[15]};
    assign diff    = shifted - {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = done_reg && !ctrl.ack;
        if (ctrl.start && !busy_reg) begin
            rem_next  = 16'd0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = 5'd16;
            busy_next = 1'b1;
            done_next = 1'b0;
        end else if (busy_reg) begin
            if (!diff[16]) begin
                rem_next = diff[15:0];
                quo_next = {quo_reg[14:0], 1'b1};
            end else begin
                rem_next = shifted[15:0];
                quo_next = {quo_reg[14:0], 1'b0};
            end
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= 5'd0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

// ===== rtl/kcc_back.sv =====
// back end: operand entry, operator capture, calculation and result register
// depends on kcc_pkg and kcc_divider
module kcc_back
    import kcc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  kcc_item_t   q_item,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_shown_kind,
    output logic [15:0] m_shown_value,
    output logic        m_divide_by_zero
);

    localparam int CW = $clog2(MAX_DIGITS + 1);
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_DIGITS);

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_OPWAIT = 2'd1;
    localparam logic [1:0] PH_SECOND = 2'd2;
    localparam logic [1:0] PH_EQWAIT = 2'd3;

    localparam logic ST_RUN = 1'b0;
    localparam logic ST_DIV = 1'b1;

    logic          st_reg, st_next;
    logic [1:0]    phase_reg, phase_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [15:0]   first_reg, first_next;
    logic [15:0]   acc_reg, acc_next;
    logic [1:0]    op_reg, op_next;
    logic          ov_reg, ov_next;
    logic [1:0]    kind_reg, kind_next;
    logic [15:0]   val_reg, val_next;
    logic          dz_reg, dz_next;

    logic          out_free;
    logic [15:0]   gathered;
    logic [CW-1:0] cnt_inc;
    logic          full;
    logic [31:0]   product;

    kcc_div_ctrl_t   div_ctrl;
    kcc_div_status_t div_status;
    logic [15:0]     div_q;

    kcc_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (first_reg),
        .divisor  (acc_reg),
        .status   (div_status),
        .quotient (div_q)
    );

    assign out_free = !ov_reg || m_ready;
    assign q_pop    = (st_reg == ST_RUN) && q_valid && out_free;
    assign gathered = (acc_reg << 3) + (acc_reg << 1) + {8'd0, q_item.key};
    assign cnt_inc  = cnt_reg + CW'(1);
    assign full     = (cnt_inc >= MAX_CNT);
    assign product  = first_reg * acc_reg;

    always_comb begin
        st_next        = st_reg;
        phase_next     = phase_reg;
        cnt_next       = cnt_reg;
        first_next     = first_reg;
        acc_next       = acc_reg;
        op_next        = op_reg;
        ov_next        = ov_reg && !m_ready;
        kind_next      = kind_reg;
        val_next       = val_reg;
        dz_next        = dz_reg;
        div_ctrl.start = 1'b0;
        div_ctrl.ack   = 1'b0;

        if (q_pop) begin
            ov_next   = 1'b1;
            kind_next = KIND_IGNORED;
            val_next  = 16'd0;
            dz_next   = 1'b0;
            if ((phase_reg == PH_OPWAIT) ||
                ((phase_reg == PH_FIRST) && q_item.is_end_op)) begin
                op_next    = q_item.op;
                first_next = acc_reg;
                acc_next   = 16'd0;
                cnt_next   = '0;
                phase_next = PH_SECOND;
                kind_next  = KIND_OPERATOR;
                val_next   = {8'd0, q_item.echo};
            end else if (phase_reg == PH_FIRST || (phase_reg == PH_SECOND && !q_item.is_eq)) begin
                acc_next  = gathered;
                cnt_next  = full ? '0 : cnt_inc;
                kind_next = KIND_DIGIT;
                val_next  = {8'd0, q_item.key};
                if (full) begin
                    phase_next = (phase_reg == PH_FIRST) ? PH_OPWAIT : PH_EQWAIT;
                end
            end else if (q_item.is_eq) begin
                phase_next = PH_FIRST;
                cnt_next   = '0;
                first_next = 16'd0;
                acc_next   = 16'd0;
                op_next    = OP_DIV;
                kind_next  = KIND_RESULT;
                unique case (op_reg)
                    OP_ADD: val_next = first_reg + acc_reg;
                    OP_SUB: val_next = first_reg - acc_reg;
                    OP_MUL: val_next = product[15:0];
                    default: begin
                        if (acc_reg == 16'd0) begin
                            val_next = 16'hFFFF;
                            dz_next  = 1'b1;
                        end else begin
                            ov_next        = ov_reg && !m_ready;
                            div_ctrl.start = 1'b1;
                            st_next        = ST_DIV;
                        end
                    end
                endcase
            end
        end else if (st_reg == ST_DIV && div_status.done && !div_status.busy && out_free) begin
            ov_next      = 1'b1;
            kind_next    = KIND_RESULT;
            val_next     = div_q;
            dz_next      = 1'b0;
            div_ctrl.ack = 1'b1;
            st_next      = ST_RUN;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_RUN;
            phase_reg <= PH_FIRST;
            cnt_reg   <= '0;
            first_reg <= 16'd0;
            acc_reg   <= 16'd0;
            op_reg    <= OP_DIV;
            ov_reg    <= 1'b0;
        end else begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
            acc_reg   <= acc_next;
            op_reg    <= op_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg <= kind_next;
        val_reg  <= val_next;
        dz_reg   <= dz_next;
    end

    assign m_valid          = ov_reg;
    assign m_shown_kind     = kind_reg;
    assign m_shown_value    = val_reg;
    assign m_divide_by_zero = dz_reg;

endmodule

// ===== rtl/keypad_calculator_controller_unit.sv =====
// top level of the keypad calculator controller
// depends on kcc_pkg, kcc_front, kcc_back
//
//  channel | direction | ports                                   | handshake
//  s_      | in        | s_key                                   | s_valid / s_ready
//  m_      | out       | m_shown_kind, m_shown_value, m_divide_by_zero | m_valid / m_ready
//
// an accepted key transaction waits in the queue until the back end pops it into the result register
// a division by a nonzero operand goes through the 16-step divider, then a handoff to the result register
// reset is synchronous, active low, and returns to first operand entry
// a two-entry queue lets keys be taken while a result waits on m_ready
module keypad_calculator_controller_unit
    import kcc_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_key,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_shown_kind,
    output logic [15:0] m_shown_value,
    output logic        m_divide_by_zero
);

    logic      q_valid;
    logic      q_pop;
    kcc_item_t q_item;

    kcc_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_key   (s_key),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    kcc_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .q_valid          (q_valid),
        .q_item           (q_item),
        .q_pop            (q_pop),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_shown_kind     (m_shown_kind),
        .m_shown_value    (m_shown_value),
        .m_divide_by_zero (m_divide_by_zero)
    );

endmodule

// ===== rtl/kcc_checker.sv =====
// port-level checker for the keypad calculator controller, bound to the top level
// depends on kcc_pkg and keypad_calculator_controller_unit_defines.svh
`include "keypad_calculator_controller_unit_defines.svh"

module kcc_checker
    import kcc_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_key,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_shown_kind,
    input logic [15:0] m_shown_value,
    input logic        m_divide_by_zero
);

    `KCC_ASSERT_NEXT(a_in_hold, aclk, aresetn, s_valid && !s_ready, s_valid && $stable(s_key), "stalled input transaction changed")
    `KCC_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_shown_value) && $stable(m_shown_kind), "stalled result transaction changed")
    `KCC_ASSERT_NOW(a_dz_value, aclk, aresetn, m_valid && m_divide_by_zero, (m_shown_kind == KIND_RESULT) && (m_shown_value == 16'hFFFF), "divide by zero flag without saturated result")
    `KCC_ASSERT_NOW(a_ignored_zero, aclk, aresetn, m_valid && (m_shown_kind == KIND_IGNORED), (m_shown_value == 16'd0) && !m_divide_by_zero, "ignored key shows a value")
    `KCC_ASSERT_NOW(a_op_echo, aclk, aresetn, m_valid && (m_shown_kind == KIND_OPERATOR), (m_shown_value != {8'd0, KEY_PCT}) && (m_shown_value[15:8] == 8'd0) && !m_divide_by_zero, "operator echo not corrected")

endmodule

bind keypad_calculator_controller_unit kcc_checker u_kcc_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_key            (s_key),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_shown_kind     (m_shown_kind),
    .m_shown_value    (m_shown_value),
    .m_divide_by_zero (m_divide_by_zero)
);
